>>> src/icmpv6_esc_pkg.sv
// Package for the ICMPv6 error suppression check.
// Holds modes, walk phases, outcomes, verdicts, header and ICMP type codes and the front-to-back struct.
// No dependencies.
package icmpv6_esc_pkg;

    localparam logic [1:0] MODE_SRC  = 2'd0;
    localparam logic [1:0] MODE_DST  = 2'd1;
    localparam logic [1:0] MODE_PKT  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [2:0] PH_FIXED     = 3'd0;
    localparam logic [2:0] PH_EXT_OPT   = 3'd1;
    localparam logic [2:0] PH_EXT_AH    = 3'd2;
    localparam logic [2:0] PH_EXT_SKIP  = 3'd3;
    localparam logic [2:0] PH_FRAG      = 3'd4;
    localparam logic [2:0] PH_FRAG_LATE = 3'd5;
    localparam logic [2:0] PH_UPPER     = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [1:0] WO_NONE     = 2'd0;
    localparam logic [1:0] WO_SUPPRESS = 2'd1;
    localparam logic [1:0] WO_INVALID  = 2'd2;
    localparam logic [1:0] WO_LONG     = 2'd3;

    localparam logic [1:0] VERDICT_ALLOW    = 2'd0;
    localparam logic [1:0] VERDICT_SUPPRESS = 2'd1;
    localparam logic [1:0] VERDICT_INVALID  = 2'd2;

    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG  = 8'd44;
    localparam logic [7:0] NH_ESP   = 8'd50;
    localparam logic [7:0] NH_AH    = 8'd51;
    localparam logic [7:0] NH_ICMP  = 8'd58;
    localparam logic [7:0] NH_NONE  = 8'd59;
    localparam logic [7:0] NH_DOPT  = 8'd60;

    localparam logic [7:0] ICMP_INFO_MIN = 8'd128;
    localparam logic [7:0] ICMP_REDIRECT = 8'd137;

    // One classified packet beat handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] flags;
        logic       allow_mc;
        logic       dst_match;
        logic       src_zero;
        logic       src_mc;
    } t_beat;

endpackage

>>> src/icmpv6_error_suppression_check.sv
// Top level of the ICMPv6 error suppression check.
// Instantiates icmpv6_esc_front, icmpv6_esc_fifo, icmpv6_esc_walk; uses icmpv6_esc_pkg.
//
//   channel  | ports                                            | handshake
//   input    | i_mode i_data_byte i_last i_invoking_flags        | i_push / o_full
//            | i_allow_multicast                                 |
//   result   | o_verdict                                         | o_empty / i_pop
//
// One beat per cycle is taken while o_full is low; a packet beat reaches
// the walker through a two-entry queue and its verdict lands in a two-entry
// result queue. The last beat is registered in the beat queue, then its
// verdict in the result queue. Address beats stay in the front. Reset is
// synchronous and clears all control state; the destination store is not
// cleared. A full result queue stalls the walker, backing up to o_full.
module icmpv6_error_suppression_check #(
    parameter int POSITION_BITS = 17
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic [7:0] i_invoking_flags,
    input  logic       i_allow_multicast,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_verdict
);
    import icmpv6_esc_pkg::*;

    logic  w_fvalid, w_qfull, w_qempty, w_wvalid, w_done;
    logic  w_rfull;
    t_beat w_fbeat, w_qbeat;
    logic [1:0] w_verdict;
    logic [4:0] r_pcnt;
    logic  w_acc;

    // The top tracks packet position in the fixed header for the front's address compare.
    assign w_acc = i_push && !o_full;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pcnt <= 5'd0;
        else if (w_acc && i_mode == MODE_PKT) begin
            if (i_last) r_pcnt <= 5'd0;
            else if (r_pcnt != 5'd31) r_pcnt <= r_pcnt + 5'd1;
        end
    end

    icmpv6_esc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(w_acc), .i_mode, .i_data_byte, .i_last, .i_invoking_flags,
        .i_allow_multicast,
        .i_cmp_index(4'(r_pcnt - 5'd8)),
        .i_cmp_active(r_pcnt >= 5'd8 && r_pcnt < 5'd24),
        .o_valid(w_fvalid), .o_beat(w_fbeat)
    );

    assign o_full = w_qfull;

    icmpv6_esc_fifo u_q (
        .i_clk, .i_rst_n,
        .i_push(w_fvalid), .i_beat(w_fbeat), .o_full(w_qfull),
        .i_pop(w_wvalid), .o_empty(w_qempty), .o_beat(w_qbeat)
    );

    assign w_wvalid = !w_qempty && !w_rfull;

    icmpv6_esc_walk #(.POSITION_BITS(POSITION_BITS)) u_walk (
        .i_clk, .i_rst_n,
        .i_valid(w_wvalid), .i_beat(w_qbeat),
        .o_done(w_done), .o_verdict(w_verdict)
    );

    logic [1:0] r_res [2];
    logic       r_rwp, r_rrp;
    logic [1:0] r_rcnt;
    assign w_rfull   = r_rcnt == 2'd2;
    assign o_empty   = r_rcnt == 2'd0;
    assign o_verdict = r_res[r_rrp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp <= 1'b0; r_rrp <= 1'b0; r_rcnt <= 2'd0;
        end else begin
            if (w_done) r_rwp <= !r_rwp;
            if (i_pop && !o_empty) r_rrp <= !r_rrp;
            r_rcnt <= r_rcnt + {1'b0, w_done} - {1'b0, i_pop && !o_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_res[r_rwp] <= w_verdict;
    end

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_verdict <= VERDICT_INVALID) else $error("verdict code out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rfull |-> !w_done) else $error("result queue overflow");
    a_walk_only_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wvalid |-> !w_qempty) else $error("walker ran on empty queue");

endmodule

>>> src/icmpv6_esc_front.sv
// Front part: takes address beats, stores the error destination and tags
// each packet beat with its byte compare result. Uses icmpv6_esc_pkg.
module icmpv6_esc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_mode,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    input  logic [7:0]            i_invoking_flags,
    input  logic                  i_allow_multicast,
    input  logic [3:0]            i_cmp_index,
    input  logic                  i_cmp_active,
    output logic                  o_valid,
    output icmpv6_esc_pkg::t_beat o_beat
);
    import icmpv6_esc_pkg::*;

    logic [7:0] r_dst [16];
    logic [4:0] r_src_cnt, n_src_cnt;
    logic [4:0] r_dst_cnt, n_dst_cnt;
    logic       r_src_zero, n_src_zero;
    logic       r_src_mc, n_src_mc;
    logic       w_src_take, w_dst_take, w_pkt;

    assign w_src_take = i_valid && (i_mode == MODE_SRC) && !r_src_cnt[4];
    assign w_dst_take = i_valid && (i_mode == MODE_DST) && !r_dst_cnt[4];
    assign w_pkt      = i_valid && (i_mode == MODE_PKT);

    always_comb begin
        n_src_cnt  = r_src_cnt;
        n_dst_cnt  = r_dst_cnt;
        n_src_zero = r_src_zero;
        n_src_mc   = r_src_mc;
        if (w_src_take) begin
            if (i_data_byte != 8'd0) n_src_zero = 1'b0;
            if (r_src_cnt == 5'd0 && i_data_byte == 8'hff) n_src_mc = 1'b1;
            n_src_cnt = r_src_cnt + 5'd1;
        end
        if (w_dst_take) n_dst_cnt = r_dst_cnt + 5'd1;
        // A verdict clears the address counts for the next check.
        if (w_pkt && i_last) begin
            n_src_cnt  = 5'd0;
            n_dst_cnt  = 5'd0;
            n_src_zero = 1'b1;
            n_src_mc   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt  <= 5'd0;
            r_dst_cnt  <= 5'd0;
            r_src_zero <= 1'b1;
            r_src_mc   <= 1'b0;
        end else begin
            r_src_cnt  <= n_src_cnt;
            r_dst_cnt  <= n_dst_cnt;
            r_src_zero <= n_src_zero;
            r_src_mc   <= n_src_mc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dst_take) r_dst[r_dst_cnt[3:0]] <= i_data_byte;
    end

    assign o_valid            = w_pkt;
    assign o_beat.data        = i_data_byte;
    assign o_beat.last        = i_last;
    assign o_beat.flags       = i_invoking_flags;
    assign o_beat.allow_mc    = i_allow_multicast;
    assign o_beat.dst_match   = !i_cmp_active || (i_data_byte == r_dst[i_cmp_index]);
    assign o_beat.src_zero    = r_src_zero;
    assign o_beat.src_mc      = r_src_mc;

endmodule

>>> src/icmpv6_esc_fifo.sv
// Small queue of classified beats between front and back.
// Uses icmpv6_esc_pkg for the beat type.
module icmpv6_esc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  icmpv6_esc_pkg::t_beat i_beat,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output icmpv6_esc_pkg::t_beat o_beat
);
    import icmpv6_esc_pkg::*;

    t_beat      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_beat  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= !r_wp;
            if (i_pop && !o_empty) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_beat;
    end

endmodule

>>> src/icmpv6_esc_walk.sv
// Back part: walks the extension header chain over packet beats and forms
// the verdict on the last beat. Uses icmpv6_esc_pkg.
module icmpv6_esc_walk #(
    parameter int POSITION_BITS = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  icmpv6_esc_pkg::t_beat i_beat,
    output logic                  o_done,
    output logic [1:0]            o_verdict
);
    import icmpv6_esc_pkg::*;

    localparam logic [POSITION_BITS-1:0] PMAX = '1;
    localparam int HW = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] r_pos, n_pos, r_end, n_end;
    logic [7:0] r_type, n_type;
    logic [2:0] r_ph, n_ph;
    logic [1:0] r_wo, n_wo;
    logic r_szero, n_szero, r_smc, n_smc, r_sdiff, n_sdiff, r_dmc, n_dmc;
    logic [8:0] r_q, n_q;

    logic [POSITION_BITS-1:0] w_start, w_rel, w_p1;
    logic [7:0] b;
    logic [HW-1:0] w_hl_end, w_next8;
    logic [1:0] w_verdict;
    logic [2:0] w_ph_mid;
    logic       w_ext;

    assign b       = i_beat.data;
    assign w_start = r_end - POSITION_BITS'(8);
    assign w_rel   = r_pos - w_start;
    assign w_p1    = r_pos + POSITION_BITS'(1);

    always_comb begin
        n_pos = r_pos; n_end = r_end; n_type = r_type; n_ph = r_ph; n_wo = r_wo;
        n_szero = r_szero; n_smc = r_smc; n_sdiff = r_sdiff; n_dmc = r_dmc;
        n_q = r_q;
        w_hl_end = '0;
        w_next8  = '0;
        w_ext    = 1'b0;
        w_ph_mid = r_ph;
        if (r_pos == PMAX) begin
            n_wo = WO_LONG;
        end else begin
            unique case (r_ph)
                PH_FIXED: begin
                    if (r_pos == '0 && b[7:4] != 4'd6 && r_wo == WO_NONE) n_wo = WO_INVALID;
                    if (r_pos == POSITION_BITS'(6)) n_type = b;
                    if (r_pos >= POSITION_BITS'(8) && r_pos < POSITION_BITS'(24)) begin
                        if (b != 8'd0) n_szero = 1'b0;
                        if (r_pos == POSITION_BITS'(8) && b == 8'hff) n_smc = 1'b1;
                        if (!i_beat.dst_match) n_sdiff = 1'b1;
                    end
                    if (r_pos == POSITION_BITS'(24) && b == 8'hff) n_dmc = 1'b1;
                end
                PH_EXT_OPT, PH_EXT_AH: begin
                    if (w_rel == '0) begin
                        n_type = b;
                    end else if (w_rel == POSITION_BITS'(1)) begin
                        if (r_ph == PH_EXT_AH)
                            w_hl_end = HW'(w_start) + (HW'(b) + HW'(2)) * HW'(4);
                        else
                            w_hl_end = HW'(w_start) + (HW'(b) + HW'(1)) * HW'(8);
                        if (w_hl_end > HW'(PMAX)) begin
                            if (r_wo == WO_NONE) n_wo = WO_INVALID;
                            n_ph = PH_DONE;
                        end else begin
                            n_end = w_hl_end[POSITION_BITS-1:0];
                            n_ph  = PH_EXT_SKIP;
                        end
                    end
                end
                PH_FRAG, PH_FRAG_LATE: begin
                    if (w_rel == '0) n_type = b;
                    else if (w_rel == POSITION_BITS'(2) && b != 8'd0) n_ph = PH_FRAG_LATE;
                    else if (w_rel == POSITION_BITS'(3) && (b & 8'hf8) != 8'd0)
                        n_ph = PH_FRAG_LATE;
                end
                PH_UPPER: begin
                    if (r_pos == r_end && r_type == NH_ICMP && !r_q[8]) n_q = {1'b1, b};
                end
                default: ;
            endcase
            n_pos = w_p1;
            // Header boundary reached: decide what follows.
            w_ph_mid = n_ph;
            if (w_ph_mid != PH_UPPER && w_ph_mid != PH_DONE && w_p1 == n_end) begin
                w_ext = n_type == NH_HOP || n_type == NH_ROUTE || n_type == NH_FRAG
                     || n_type == NH_AH || n_type == NH_DOPT;
                w_next8 = HW'(w_p1) + HW'(8);
                if (n_wo != WO_NONE) begin
                    n_ph = PH_DONE;
                end else if (w_ph_mid == PH_FRAG_LATE) begin
                    n_wo = WO_SUPPRESS; n_ph = PH_DONE;
                end else if (w_ext) begin
                    if (w_next8 > HW'(PMAX)) begin
                        n_wo = WO_INVALID; n_ph = PH_DONE;
                    end else begin
                        n_end = w_next8[POSITION_BITS-1:0];
                        n_ph  = (n_type == NH_FRAG) ? PH_FRAG
                              : (n_type == NH_AH) ? PH_EXT_AH : PH_EXT_OPT;
                    end
                end else if (n_type == NH_ESP) begin
                    n_wo = WO_SUPPRESS; n_ph = PH_DONE;
                end else begin
                    n_ph = PH_UPPER;
                end
            end
        end
    end

    always_comb begin
        w_verdict = VERDICT_ALLOW;
        priority if (i_beat.flags[7:4] != 4'd0) w_verdict = VERDICT_INVALID;
        else if (i_beat.src_zero || i_beat.src_mc) w_verdict = VERDICT_INVALID;
        else if (n_wo == WO_LONG || n_wo == WO_INVALID) w_verdict = VERDICT_INVALID;
        else if (n_wo == WO_SUPPRESS) w_verdict = VERDICT_SUPPRESS;
        else if (n_ph != PH_UPPER) w_verdict = VERDICT_INVALID;
        else if (i_beat.flags[1:0] != 2'd0 || n_szero || n_smc) w_verdict = VERDICT_SUPPRESS;
        else if (n_sdiff) w_verdict = VERDICT_INVALID;
        else if (!i_beat.allow_mc && (i_beat.flags[3:2] != 2'd0 || n_dmc))
            w_verdict = VERDICT_SUPPRESS;
        else if (n_type == NH_ICMP) begin
            if (!n_q[8]) w_verdict = VERDICT_INVALID;
            else if (n_q[7:0] < ICMP_INFO_MIN || n_q[7:0] == ICMP_REDIRECT)
                w_verdict = VERDICT_SUPPRESS;
        end else if (n_type == NH_NONE && n_end != n_pos) w_verdict = VERDICT_INVALID;
    end

    assign o_done    = i_valid && i_beat.last;
    assign o_verdict = w_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_pos <= '0; r_end <= POSITION_BITS'(40); r_type <= 8'd0;
            r_ph <= PH_FIXED; r_wo <= WO_NONE; r_szero <= 1'b1; r_smc <= 1'b0;
            r_sdiff <= 1'b0; r_dmc <= 1'b0; r_q <= 9'd0;
        end else if (i_valid) begin
            r_pos <= n_pos; r_end <= n_end; r_type <= n_type; r_ph <= n_ph;
            r_wo <= n_wo; r_szero <= n_szero; r_smc <= n_smc; r_sdiff <= n_sdiff;
            r_dmc <= n_dmc; r_q <= n_q;
        end
    end

endmodule

>>> test/icmpv6_esc_checker.sv
// Checker for the ICMPv6 error suppression check: watches both queue ports,
// predicts each verdict from the accepted beats and compares it.
// Depends on icmpv6_esc_pkg.
module icmpv6_esc_checker
    import icmpv6_esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic [7:0] i_invoking_flags,
    input  logic       i_allow_multicast,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_verdict,
    output int         o_pending,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POSITION_BITS = 17;
    localparam logic [31:0] POS_MAX       = (32'd1 << POSITION_BITS) - 32'd1;

    logic [1:0]  verdict_q[$];
    int          fail_count;

    logic [4:0]  src_count;
    logic [4:0]  dst_count;
    logic        src_zero;
    logic        src_mc;
    logic [7:0]  dst_store[16];
    logic [31:0] pos;
    logic [7:0]  hdr_type;
    logic [31:0] hdr_end;
    logic [2:0]  phase;
    logic [1:0]  outcome;
    logic        mk_src_zero;
    logic        mk_src_mc;
    logic        mk_src_diff;
    logic        mk_dst_mc;
    logic        quoted_seen;
    logic [7:0]  quoted_type;

    assign o_pending    = verdict_q.size();
    assign o_fail_count = fail_count;

    task automatic clear_check();
        src_count   = '0;
        dst_count   = '0;
        src_zero    = 1'b1;
        src_mc      = 1'b0;
        pos         = '0;
        hdr_type    = '0;
        hdr_end     = 32'd40;
        phase       = PH_FIXED;
        outcome     = WO_NONE;
        mk_src_zero = 1'b1;
        mk_src_mc   = 1'b0;
        mk_src_diff = 1'b0;
        mk_dst_mc   = 1'b0;
        quoted_seen = 1'b0;
        quoted_type = '0;
    endtask

    task automatic stop_walk(input logic [1:0] why);
        if (outcome == WO_NONE) begin
            outcome = why;
        end
        phase = PH_DONE;
    endtask

    // Runs when the byte count reaches the end of the current header.
    task automatic cross_boundary();
        logic [31:0] next_end;
        if (outcome != WO_NONE) begin
            phase = PH_DONE;
        end else if (phase == PH_FRAG_LATE) begin
            stop_walk(WO_SUPPRESS);
        end else if (hdr_type == NH_HOP || hdr_type == NH_ROUTE || hdr_type == NH_FRAG ||
                     hdr_type == NH_AH || hdr_type == NH_DOPT) begin
            next_end = pos + 32'd8;
            if (next_end > POS_MAX) begin
                stop_walk(WO_INVALID);
            end else begin
                hdr_end = next_end;
                phase = (hdr_type == NH_FRAG) ? PH_FRAG :
                        (hdr_type == NH_AH) ? PH_EXT_AH : PH_EXT_OPT;
            end
        end else if (hdr_type == NH_ESP) begin
            stop_walk(WO_SUPPRESS);
        end else begin
            phase = PH_UPPER;
        end
    endtask

    task automatic walk_packet_byte(input logic [7:0] b);
        logic [31:0] p;
        logic [31:0] start;
        logic [31:0] rel;
        logic [31:0] hlen;
        p     = pos;
        start = hdr_end - 32'd8;
        rel   = p - start;
        if (p >= POS_MAX) begin
            outcome = WO_LONG;
            return;
        end
        case (phase)
            PH_FIXED: begin
                if (p == 0 && b[7:4] != 4'd6 && outcome == WO_NONE) begin
                    outcome = WO_INVALID;
                end
                if (p == 6) begin
                    hdr_type = b;
                end
                if (p >= 8 && p < 24) begin
                    if (b != 8'd0) mk_src_zero = 1'b0;
                    if (p == 8 && b == 8'hff) mk_src_mc = 1'b1;
                    if (b != dst_store[p[3:0] - 4'd8]) mk_src_diff = 1'b1;
                end
                if (p == 24 && b == 8'hff) begin
                    mk_dst_mc = 1'b1;
                end
            end
            PH_EXT_OPT, PH_EXT_AH: begin
                if (rel == 0) begin
                    hdr_type = b;
                end else if (rel == 1) begin
                    if (phase == PH_EXT_AH) hlen = (32'(b) + 32'd2) * 32'd4;
                    else hlen = (32'(b) + 32'd1) * 32'd8;
                    if (start + hlen > POS_MAX) begin
                        stop_walk(WO_INVALID);
                    end else begin
                        hdr_end = start + hlen;
                        phase = PH_EXT_SKIP;
                    end
                end
            end
            PH_FRAG, PH_FRAG_LATE: begin
                if (rel == 0) hdr_type = b;
                else if (rel == 2 && b != 8'd0) phase = PH_FRAG_LATE;
                else if (rel == 3 && (b & 8'hf8) != 8'd0) phase = PH_FRAG_LATE;
            end
            PH_UPPER: begin
                if (p == hdr_end && hdr_type == NH_ICMP && !quoted_seen) begin
                    quoted_seen = 1'b1;
                    quoted_type = b;
                end
            end
            default: ;
        endcase
        pos = p + 32'd1;
        if (phase != PH_UPPER && phase != PH_DONE && pos == hdr_end) begin
            cross_boundary();
        end
    endtask

    function automatic logic [1:0] verdict_for(input logic [7:0] flags, input logic amc);
        if (flags[7:4] != 4'd0) return VERDICT_INVALID;
        if (src_zero || src_mc) return VERDICT_INVALID;
        if (outcome == WO_LONG || outcome == WO_INVALID) return VERDICT_INVALID;
        if (outcome == WO_SUPPRESS) return VERDICT_SUPPRESS;
        if (phase != PH_UPPER) return VERDICT_INVALID;
        if (flags[1:0] != 2'd0 || mk_src_zero || mk_src_mc) return VERDICT_SUPPRESS;
        if (mk_src_diff) return VERDICT_INVALID;
        if (!amc && (flags[3:2] != 2'd0 || mk_dst_mc)) return VERDICT_SUPPRESS;
        if (hdr_type == NH_ICMP) begin
            if (!quoted_seen) return VERDICT_INVALID;
            if (quoted_type < ICMP_INFO_MIN || quoted_type == ICMP_REDIRECT) begin
                return VERDICT_SUPPRESS;
            end
        end else if (hdr_type == NH_NONE && hdr_end != pos) begin
            return VERDICT_INVALID;
        end
        return VERDICT_ALLOW;
    endfunction

    initial begin
        fail_count = 0;
        clear_check();
        foreach (dst_store[k]) dst_store[k] = '0;
    end

    always @(posedge i_clk) begin
        logic [1:0] want;
        if (!i_rst_n) begin
            clear_check();
            verdict_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected verdict beat %0d", i_verdict);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_verdict) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("verdict mismatch: expected %0d actual %0d",
                                     want, i_verdict);
                        end
                    end
                end
            end
            if (i_push && !i_full) begin
                case (i_mode)
                    MODE_SRC: begin
                        if (src_count < 5'd16) begin
                            if (i_data_byte != 8'd0) src_zero = 1'b0;
                            if (src_count == 0 && i_data_byte == 8'hff) src_mc = 1'b1;
                            src_count++;
                        end
                    end
                    MODE_DST: begin
                        if (dst_count < 5'd16) begin
                            dst_store[dst_count[3:0]] = i_data_byte;
                            dst_count++;
                        end
                    end
                    MODE_PKT: begin
                        walk_packet_byte(i_data_byte);
                        if (i_last) begin
                            verdict_q.push_back(verdict_for(i_invoking_flags,
                                                            i_allow_multicast));
                            clear_check();
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> test/tb_icmpv6_error_suppression_check.sv
// Testbench top for the ICMPv6 error suppression check: builds address and
// packet beats, idles both sides and reports pass or fail.
// Depends on icmpv6_esc_pkg, icmpv6_esc_checker and the block itself.
module tb_icmpv6_error_suppression_check;
    import icmpv6_esc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_GOAL   = 1950;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [1:0] i_mode;
    logic [7:0] i_data_byte;
    logic       i_last;
    logic [7:0] i_invoking_flags;
    logic       i_allow_multicast;
    logic       o_empty;
    logic       i_pop;
    logic [1:0] o_verdict;
    int         pending;
    int         fail_count;

    int         cycles;
    int         items;
    bit         quiet;
    int         pop_hold;
    logic [7:0] err_src[16];
    logic [7:0] err_dst[16];
    logic [7:0] pkt[$];

    icmpv6_error_suppression_check u_dut (.*);

    icmpv6_esc_checker u_checker (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_mode, .i_data_byte, .i_last,
        .i_invoking_flags, .i_allow_multicast, .i_empty(o_empty), .i_pop,
        .i_verdict(o_verdict), .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The result side stalls in bursts, except near the end of the run.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold--;
            i_pop = 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(0, 14);
            i_pop = 1'b0;
        end else begin
            i_pop = 1'b1;
        end
    end

    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            n = $urandom_range(1, 15);
            @(negedge i_clk);
            i_push = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // One beat: drive at the falling edge, hold until the queue takes it.
    task automatic put_beat(input logic [1:0] mode, input logic [7:0] b, input logic lst,
                            input logic [7:0] flags, input logic amc);
        sender_gap();
        @(negedge i_clk);
        i_push = 1'b1;
        i_mode = mode;
        i_data_byte = b;
        i_last = lst;
        i_invoking_flags = flags;
        i_allow_multicast = amc;
        while (o_full) @(negedge i_clk);
        if (mode != MODE_RSVD) items++;
    endtask

    task automatic send_addresses();
        foreach (err_src[k]) put_beat(MODE_SRC, err_src[k], 1'($urandom), 8'($urandom),
                                      1'($urandom));
        foreach (err_dst[k]) put_beat(MODE_DST, err_dst[k], 1'b0, 8'd0, 1'b0);
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic amc);
        foreach (pkt[k]) begin
            if (k == pkt.size() - 1) put_beat(MODE_PKT, pkt[k], 1'b1, flags, amc);
            else put_beat(MODE_PKT, pkt[k], 1'b0, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic pick_addresses();
        foreach (err_src[k]) err_src[k] = 8'($urandom);
        err_src[0] = 8'h20;
        foreach (err_dst[k]) err_dst[k] = 8'($urandom);
    endtask

    // Fixed header with the invoking source equal to the error destination.
    task automatic fixed_header(input logic [7:0] nh);
        pkt.delete();
        pkt.push_back(8'h60);
        repeat (5) pkt.push_back(8'($urandom));
        pkt.push_back(nh);
        pkt.push_back(8'($urandom));
        foreach (err_dst[k]) pkt.push_back(err_dst[k]);
        pkt.push_back(8'h20);
        repeat (15) pkt.push_back(8'($urandom));
    endtask

    task automatic directed(input logic [7:0] nh, input logic [7:0] t,
                            input logic [7:0] flags, input logic amc);
        fixed_header(nh);
        pkt.push_back(t);
        repeat (3) pkt.push_back(8'($urandom));
        send_addresses();
        send_packet(flags, amc);
    endtask

    task automatic random_check();
        logic [7:0] chain[$];
        logic [7:0] ext[5];
        logic [7:0] upper;
        logic [7:0] len;
        int         total;
        int         n;
        ext = '{NH_HOP, NH_ROUTE, NH_FRAG, NH_AH, NH_DOPT};
        pick_addresses();
        case ($urandom_range(0, 11))
            0: foreach (err_src[k]) err_src[k] = 8'd0;
            1: err_src[0] = 8'hff;
            default: ;
        endcase
        n = $urandom_range(0, 3);
        repeat (n) chain.push_back(ext[$urandom_range(0, 4)]);
        case ($urandom_range(0, 7))
            0: upper = NH_NONE;
            1: upper = NH_ESP;
            2: upper = 8'($urandom);
            default: upper = NH_ICMP;
        endcase
        chain.push_back(upper);
        fixed_header(chain[0]);
        if ($urandom_range(0, 15) == 0) pkt[0] = 8'($urandom);
        if ($urandom_range(0, 9) == 0) pkt[8 + $urandom_range(0, 15)] = 8'($urandom);
        if ($urandom_range(0, 5) == 0) pkt[24] = 8'hff;
        for (int h = 0; h < n; h++) begin
            if (chain[h] == NH_AH) begin
                len = 8'($urandom_range(0, 2));
                total = (len + 2) * 4;
            end else if (chain[h] == NH_FRAG) begin
                len = 8'($urandom);
                total = 8;
            end else begin
                len = 8'($urandom_range(0, 1));
                total = (len + 1) * 8;
            end
            pkt.push_back(chain[h + 1]);
            pkt.push_back(len);
            if (chain[h] == NH_FRAG) begin
                pkt.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0);
                pkt.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
                total -= 2;
            end
            repeat (total - 2) pkt.push_back(8'($urandom));
        end
        if (upper == NH_ICMP) begin
            pkt.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(128, 255)));
            repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
        end else if (upper != NH_NONE || $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, pkt.size());
            while (pkt.size() > n) void'(pkt.pop_back());
        end
        if ($urandom_range(0, 19) == 0)
            put_beat(MODE_RSVD, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
        send_addresses();
        if ($urandom_range(0, 19) == 0) put_beat(MODE_DST, 8'($urandom), 1'b0, 8'd0, 1'b0);
        send_packet($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0, 1'($urandom));
    endtask

    initial begin
        cycles = 0;
        items = 0;
        quiet = 1'b0;
        pop_hold = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_mode = MODE_SRC;
        i_data_byte = '0;
        i_last = 1'b0;
        i_invoking_flags = '0;
        i_allow_multicast = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        pick_addresses();
        directed(NH_ICMP, 8'd128, 8'd0, 1'b0);
        directed(NH_ICMP, 8'd255, 8'h10, 1'b0);
        directed(NH_ICMP, 8'd127, 8'h01, 1'b0);
        directed(NH_ICMP, 8'd130, 8'h02, 1'b0);
        directed(NH_ICMP, ICMP_REDIRECT, 8'd0, 1'b0);
        directed(NH_ICMP, 8'd0, 8'h04, 1'b0);
        directed(NH_ICMP, 8'd129, 8'h08, 1'b1);
        directed(NH_ESP, 8'd0, 8'd0, 1'b0);
        directed(NH_NONE, 8'd0, 8'd0, 1'b0);
        directed(8'd6, 8'hff, 8'd0, 1'b1);
        // Unspecified and multicast error sources.
        foreach (err_src[k]) err_src[k] = 8'd0;
        fixed_header(NH_ICMP);
        pkt.push_back(8'd128);
        send_addresses();
        send_packet(8'd0, 1'b0);
        err_src[0] = 8'hff;
        send_addresses();
        send_packet(8'd0, 1'b0);
        // Bad version, then a packet shorter than the fixed header.
        pick_addresses();
        fixed_header(NH_ICMP);
        pkt[0] = 8'h45;
        pkt.push_back(8'd128);
        send_addresses();
        send_packet(8'd0, 1'b0);
        fixed_header(NH_ICMP);
        repeat (20) void'(pkt.pop_back());
        send_addresses();
        send_packet(8'd0, 1'b0);
        // Non-initial fragment header.
        fixed_header(NH_FRAG);
        pkt.push_back(NH_ICMP);
        pkt.push_back(8'd0);
        pkt.push_back(8'h01);
        pkt.push_back(8'h08);
        repeat (4) pkt.push_back(8'd0);
        pkt.push_back(8'd128);
        send_addresses();
        send_packet(8'd0, 1'b0);
        // Surplus address beats, a last on an address beat, an unused mode.
        put_beat(MODE_RSVD, 8'hff, 1'b1, 8'hff, 1'b1);
        send_addresses();
        put_beat(MODE_SRC, 8'hff, 1'b1, 8'hff, 1'b1);
        put_beat(MODE_DST, 8'h00, 1'b1, 8'hff, 1'b1);
        directed(NH_ICMP, 8'd128, 8'd0, 1'b0);
        // Let every outstanding verdict drain before the random part.
        @(negedge i_clk);
        i_push = 1'b0;
        wait (pending == 0);

        while (items < ITEM_GOAL) begin
            if (items > ITEM_GOAL - 200) quiet = 1'b1;
            random_check();
            if ($urandom_range(0, 49) == 0) begin
                @(negedge i_clk);
                i_push = 1'b0;
                wait (pending == 0);
            end
        end
        @(negedge i_clk);
        i_push = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/icmpv6_esc_pkg.sv
src/icmpv6_esc_front.sv
src/icmpv6_esc_fifo.sv
src/icmpv6_esc_walk.sv
src/icmpv6_error_suppression_check.sv
test/icmpv6_esc_checker.sv
test/tb_icmpv6_error_suppression_check.sv
